[sv/fir21_pkg.sv]
// ----------------------------------------------------------------------------
// FIR filter package
// Types and constants shared by the tap cells, the output stage and the top.
// ----------------------------------------------------------------------------
`default_nettype none

package fir21_pkg;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned PROD_W = 2 * DATA_W;
  // Q8.30 holds the exact sum of up to 64 full-scale products.
  localparam int unsigned ACC_W  = 38;
  localparam int unsigned FRAC_W = 15;

  // Item kinds carried on the op field.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // One item as it travels down the row of tap cells.
  typedef struct packed {
    logic                     valid;
    logic                     op;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] carry;
    logic signed [ACC_W-1:0]  acc;
  } token_t;

endpackage

`default_nettype wire

[sv/fir21_cell.sv]
// ----------------------------------------------------------------------------
// FIR tap cell
// Holds one tap weight and one history sample, and adds its product to the
// partial sum of each sample item that passes through it.
// ----------------------------------------------------------------------------
`default_nettype none

module fir21_cell #(
  parameter int unsigned TAP = 0
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire fir21_pkg::token_t tok_i,
  output fir21_pkg::token_t     tok_o
);

  localparam logic [fir21_pkg::IDX_W-1:0] TapIdx = fir21_pkg::IDX_W'(TAP);

  logic signed [fir21_pkg::DATA_W-1:0] coef_q;
  logic signed [fir21_pkg::DATA_W-1:0] hist_q;
  fir21_pkg::token_t                   tok_q;
  fir21_pkg::token_t                   tok_d;
  logic signed [fir21_pkg::PROD_W-1:0] prod;
  logic                                is_sample;
  logic                                is_load;

  assign is_sample = tok_i.valid && (tok_i.op == fir21_pkg::OP_SAMPLE);
  assign is_load   = tok_i.valid && (tok_i.op == fir21_pkg::OP_LOAD) && (tok_i.idx == TapIdx);
  assign prod      = coef_q * tok_i.carry;

  // A sample leaves with the sample this cell held, which is the one the
  // next cell must see; a load carries its weight on unchanged.
  always_comb begin
    tok_d = tok_i;
    if (is_sample) begin
      tok_d.carry = hist_q;
      tok_d.acc   = tok_i.acc + fir21_pkg::ACC_W'(prod);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
      hist_q <= '0;
      tok_q  <= '0;
    end else if (adv_i) begin
      tok_q <= tok_d;
      if (is_sample) begin
        hist_q <= tok_i.carry;
      end
      if (is_load) begin
        coef_q <= tok_i.carry;
      end
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

[sv/fir21_round.sv]
// ----------------------------------------------------------------------------
// FIR output stage
// Rounds the finished sum to Q1.15 with saturation and holds results in an
// output register backed by one skid slot.
// ----------------------------------------------------------------------------
`default_nettype none

module fir21_round (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire fir21_pkg::token_t               tok_i,
  output logic                                 stall_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic signed [fir21_pkg::DATA_W-1:0] filtered_o,
  output logic                                 clipped_o
);

  localparam int unsigned SUM_W = fir21_pkg::ACC_W + 1;
  localparam int unsigned RND_W = SUM_W - fir21_pkg::FRAC_W;

  logic signed [SUM_W-1:0]            biased;
  logic signed [RND_W-1:0]            rounded;
  logic signed [fir21_pkg::DATA_W-1:0] res_val;
  logic                                res_clip;
  logic                                res_valid;
  logic                                out_free;

  logic                                out_valid_q;
  logic signed [fir21_pkg::DATA_W-1:0] out_val_q;
  logic                                out_clip_q;
  logic                                skid_valid_q;
  logic signed [fir21_pkg::DATA_W-1:0] skid_val_q;
  logic                                skid_clip_q;

  // Adding half an output step and dropping the fraction rounds half up.
  assign biased  = SUM_W'(tok_i.acc) + SUM_W'(1 << (fir21_pkg::FRAC_W - 1));
  assign rounded = biased[SUM_W-1:fir21_pkg::FRAC_W];

  always_comb begin
    res_clip = 1'b0;
    res_val  = rounded[fir21_pkg::DATA_W-1:0];
    if (rounded > RND_W'(32767)) begin
      res_clip = 1'b1;
      res_val  = 16'sh7fff;
    end else if (rounded < -RND_W'(32768)) begin
      res_clip = 1'b1;
      res_val  = -16'sh8000;
    end
  end

  // The chain only moves while the skid slot is empty, so the tail item is
  // taken here exactly once.
  assign res_valid = tok_i.valid && (tok_i.op == fir21_pkg::OP_SAMPLE) && !skid_valid_q;
  assign out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_free) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (res_valid) begin
        if (out_free) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_free) begin
        out_val_q  <= skid_val_q;
        out_clip_q <= skid_clip_q;
      end
    end else if (res_valid) begin
      if (out_free) begin
        out_val_q  <= res_val;
        out_clip_q <= res_clip;
      end else begin
        skid_val_q  <= res_val;
        skid_clip_q <= res_clip;
      end
    end
  end

  assign stall_o     = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign filtered_o  = out_val_q;
  assign clipped_o   = out_clip_q;

endmodule

`default_nettype wire

[sv/fir_filter_21_tap_core.sv]
// ----------------------------------------------------------------------------
// FIR filter core
// Direct-form FIR over Q1.15 audio built as a row of tap cells; coefficient
// loads and samples share one input channel.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o  | op_i, tap_index_i, value_i
//  out     | output    | out_valid_o / out_stall_i| filtered_o, clipped_o
//
// One item is taken every cycle while in_stall_o is low; each item walks the
// row of TAPS cells, one cell per cycle while the row is not held, and a
// sample's result is registered in the output stage after the last cell.
// Reset clears every tap weight and every history sample at once.
// When the output is stalled, results collect in the output register and a
// single skid slot; once the slot fills, in_stall_o rises and the row holds.
// Loads travel the row in order with samples, so a weight changes exactly
// between the two items around it.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_filter_21_tap_core #(
  parameter int unsigned TAPS = 21
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic                                   op_i,
  input  wire logic [fir21_pkg::IDX_W-1:0]            tap_index_i,
  input  wire logic signed [fir21_pkg::DATA_W-1:0]    value_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic signed [fir21_pkg::DATA_W-1:0]         filtered_o,
  output logic                                        clipped_o
);

  fir21_pkg::token_t tok [TAPS+1];
  logic              stall;
  logic              adv;

  assign adv        = !stall;
  assign in_stall_o = stall;

  always_comb begin
    tok[0].valid = in_valid_i;
    tok[0].op    = op_i;
    tok[0].idx   = tap_index_i;
    tok[0].carry = value_i;
    tok[0].acc   = '0;
  end

  // Cell k sees the sample k items back and so holds weight TAPS-1-k.
  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    fir21_cell #(
      .TAP (TAPS - 1 - k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1])
    );
  end

  fir21_round u_round (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (tok[TAPS]),
    .stall_o     (stall),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .filtered_o  (filtered_o),
    .clipped_o   (clipped_o)
  );

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIR filter core testbench
// Streams tap weight loads and audio samples into the 21-tap filter and checks
// every filtered result against a cycle-free golden filter kept in the bench.
// Directed cases cover cleared state, rounding and saturation; random streams
// run under varied idling and a long output hold-off.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int unsigned TAPS = 21;

  typedef struct packed {
    logic signed [fir21_pkg::DATA_W-1:0] filtered;
    logic                                clipped;
  } fir_result_t;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                in_valid_i;
  logic                                in_stall_o;
  logic                                op_i;
  logic [fir21_pkg::IDX_W-1:0]         tap_index_i;
  logic signed [fir21_pkg::DATA_W-1:0] value_i;
  logic                                out_valid_o;
  logic                                out_stall_i;
  logic signed [fir21_pkg::DATA_W-1:0] filtered_o;
  logic                                clipped_o;

  // Golden filter state, updated as items are accepted.
  logic signed [fir21_pkg::DATA_W-1:0] tap_weight [TAPS];
  logic signed [fir21_pkg::DATA_W-1:0] sample_line [TAPS-1];
  fir_result_t                         filter_out_q [$];

  int err_cnt        = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;

  fir_filter_21_tap_core #(
    .TAPS(TAPS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .tap_index_i(tap_index_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .filtered_o (filtered_o),
    .clipped_o  (clipped_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAIL fir_filter_21_tap_core");
    $finish;
  end

  // Filters one sample: the newest sample meets the highest-indexed weight.
  function automatic fir_result_t filter_sample(
    input logic signed [fir21_pkg::DATA_W-1:0] x);
    longint      acc;
    longint      rnd;
    fir_result_t r;
    acc = longint'(tap_weight[TAPS-1]) * longint'(x);
    for (int m = 1; m < TAPS; m++) begin
      acc += longint'(tap_weight[TAPS-1-m]) * longint'(sample_line[m-1]);
    end
    // Add half an LSB and floor, so ties round toward plus infinity.
    rnd = (acc + 64'sd16384) >>> fir21_pkg::FRAC_W;
    r.clipped = 1'b0;
    if (rnd > 32767) begin
      rnd = 32767;
      r.clipped = 1'b1;
    end else if (rnd < -32768) begin
      rnd = -32768;
      r.clipped = 1'b1;
    end
    r.filtered = rnd[fir21_pkg::DATA_W-1:0];
    for (int m = TAPS - 2; m > 0; m--) begin
      sample_line[m] = sample_line[m-1];
    end
    sample_line[0] = x;
    return r;
  endfunction

  // Input acceptance feeds the golden filter; output acceptance is checked.
  always @(posedge clk_i) begin
    fir_result_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (op_i == fir21_pkg::OP_SAMPLE) begin
          filter_out_q.push_back(filter_sample(value_i));
        end else if (tap_index_i < TAPS) begin
          tap_weight[tap_index_i] = value_i;
        end
      end
      if (out_valid_o && !out_stall_i) begin
        if (filter_out_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result: filtered %0d clipped %0b", $time,
                   filtered_o, clipped_o);
        end else begin
          want = filter_out_q.pop_front();
          if (filtered_o !== want.filtered) begin
            err_cnt++;
            $display("%0t: filtered mismatch: expected %0d, actual %0d", $time,
                     want.filtered, filtered_o);
          end
          if (clipped_o !== want.clipped) begin
            err_cnt++;
            $display("%0t: clipped mismatch: expected %0b, actual %0b", $time,
                     want.clipped, clipped_o);
          end
        end
      end
    end
  end

  // Output side: random stalls, or a counted hold-off when one is requested.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Offers one item and returns right after the edge that accepts it.
  // Valid stays high afterwards so back-to-back items need no extra edge.
  task automatic send_item(input logic op, input logic [fir21_pkg::IDX_W-1:0] idx,
                           input logic signed [fir21_pkg::DATA_W-1:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    tap_index_i <= idx;
    value_i     <= val;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic load_tap(input logic [fir21_pkg::IDX_W-1:0] idx,
                          input logic signed [fir21_pkg::DATA_W-1:0] val);
    send_item(fir21_pkg::OP_LOAD, idx, val);
  endtask

  // The tap index is random on samples since the block must ignore it.
  task automatic feed_sample(input logic signed [fir21_pkg::DATA_W-1:0] val);
    send_item(fir21_pkg::OP_SAMPLE, fir21_pkg::IDX_W'($urandom_range(0, 63)), val);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (filter_out_q.size() != 0) @(posedge clk_i);
  endtask

  // With all weights cleared every output is zero, and loads past the last
  // tap must not land anywhere.
  task automatic test_cleared_state();
    feed_sample(16'sh7FFF);
    feed_sample(16'sh8000);
    load_tap(6'd21, 16'sh7FFF);
    load_tap(6'd63, 16'sh8000);
    feed_sample(16'sh7FFF);
    feed_sample(16'sh0000);
  endtask

  // A weight of one half on a sample of one LSB lands exactly on a tie.
  task automatic test_rounding();
    load_tap(6'd20, 16'sh4000);
    feed_sample(16'sh0001);
    feed_sample(-16'sh0001);
    feed_sample(16'sh0003);
    feed_sample(-16'sh0003);
  endtask

  task automatic test_saturation();
    load_tap(6'd20, 16'sh8000);
    feed_sample(16'sh8000);
    load_tap(6'd19, 16'sh8000);
    feed_sample(16'sh7FFF);
    feed_sample(16'sh7FFF);
    load_tap(6'd0, 16'sh7FFF);
    feed_sample(16'sh8000);
    feed_sample(16'sh8000);
  endtask

  // Mostly samples with occasional weight updates; a few loads miss the store.
  task automatic test_random_stream(input int n_items);
    int                                  done;
    int                                  pick;
    logic [fir21_pkg::IDX_W-1:0]         idx;
    logic signed [fir21_pkg::DATA_W-1:0] val;
    done = 0;
    while (done < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        if ($urandom_range(0, 99) < 15) begin
          val = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end else begin
          val = fir21_pkg::DATA_W'($urandom);
        end
        feed_sample(val);
        done++;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          val = fir21_pkg::DATA_W'($urandom_range(0, 4095)) - 16'sd2048;
        end else if (pick < 85) begin
          val = fir21_pkg::DATA_W'($urandom);
        end else begin
          val = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end
        if ($urandom_range(0, 9) == 0) begin
          idx = fir21_pkg::IDX_W'($urandom_range(TAPS, 63));
        end else begin
          idx = fir21_pkg::IDX_W'($urandom_range(0, TAPS - 1));
          done++;
        end
        load_tap(idx, val);
      end
    end
  endtask

  // The output holds off long enough for the row and the skid slot to fill,
  // so the input must stall while the sender keeps offering samples.
  task automatic test_backpressure();
    send_idle_pct = 0;
    wait_drained();
    hold_left = 300;
    repeat (120) feed_sample(fir21_pkg::DATA_W'($urandom));
    wait_drained();
    repeat (60) feed_sample(fir21_pkg::DATA_W'($urandom));
    wait_drained();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    op_i        = fir21_pkg::OP_LOAD;
    tap_index_i = '0;
    value_i     = '0;
    for (int i = 0; i < TAPS; i++) tap_weight[i] = '0;
    for (int i = 0; i < TAPS - 1; i++) sample_line[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_cleared_state();
    test_rounding();
    test_saturation();

    send_idle_pct  = 11;
    recv_stall_pct = 51;
    test_random_stream(500);

    test_backpressure();

    send_idle_pct  = 51;
    recv_stall_pct = 11;
    test_random_stream(500);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_stream(520);

    wait_drained();
    repeat (60) @(posedge clk_i);
    if (err_cnt == 0 && filter_out_q.size() == 0) begin
      $display("PASS fir_filter_21_tap_core");
    end else begin
      $display("FAIL fir_filter_21_tap_core");
    end
    $finish;
  end

endmodule

[fir_filter_21_tap_core.f]
sv/fir21_pkg.sv
sv/fir21_cell.sv
sv/fir21_round.sv
sv/fir_filter_21_tap_core.sv
dv/tb_top.sv
